/* rtl/awb_pkg.sv */
// awb gain register writer: shared constants, types and tables
`timescale 1ns / 1ps
package awb_pkg;

	localparam int RATIO_BITS = 10;
	localparam int DEN_W = RATIO_BITS + 10;
	localparam int DIV_BPS = 4;
	localparam int DIV_STAGES = (RATIO_BITS + 20 + DIV_BPS - 1) / DIV_BPS;
	localparam int NUM_W = DIV_STAGES * DIV_BPS;
	localparam int GAIN_W = 16;
	localparam int SLOTS = 8;

	localparam logic [9:0] UNITY_RATIO = 10'd1000;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0400;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_NONE  = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic err;
	} div_tag_t;

	typedef struct packed {
		logic [DEN_W:0] rem;
		logic [NUM_W-1:0] nq;
	} div_st_t;

	// write slots: red hi/lo, green hi/lo twice, blue hi/lo
	function automatic logic [15:0] slot_addr(logic [2:0] slot);
		logic [15:0] a;
		unique case (slot)
			3'd0: a = 16'h5106;
			3'd1: a = 16'h5107;
			3'd2: a = 16'h5102;
			3'd3: a = 16'h5103;
			3'd4: a = 16'h5104;
			3'd5: a = 16'h5105;
			3'd6: a = 16'h5100;
			default: a = 16'h5101;
		endcase
		return a;
	endfunction

endpackage

/* rtl/awb_div.sv */
// awb gain register writer: pipelined restoring divider, four quotient bits per stage
`timescale 1ns / 1ps
module awb_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [awb_pkg::NUM_W-1:0]    num,
	input  logic [awb_pkg::DEN_W-1:0]    den,
	input  awb_pkg::div_tag_t            tag,
	output logic                         out_valid,
	output logic [awb_pkg::NUM_W-1:0]    quo,
	output awb_pkg::div_tag_t            out_tag
);

	logic                       valid_s [awb_pkg::DIV_STAGES];
	awb_pkg::div_st_t           st_s    [awb_pkg::DIV_STAGES];
	logic [awb_pkg::DEN_W-1:0]  den_s   [awb_pkg::DIV_STAGES];
	awb_pkg::div_tag_t          tag_s   [awb_pkg::DIV_STAGES];
	awb_pkg::div_st_t           init;

	function automatic awb_pkg::div_st_t div_step(awb_pkg::div_st_t st,
			logic [awb_pkg::DEN_W-1:0] d);
		awb_pkg::div_st_t r;
		logic [awb_pkg::DEN_W:0] t;
		r = st;
		for (int k = 0; k < awb_pkg::DIV_BPS; k++) begin
			t = {r.rem[awb_pkg::DEN_W-1:0], r.nq[awb_pkg::NUM_W-1]};
			r.nq = {r.nq[awb_pkg::NUM_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				r.nq[0] = 1'b1;
			end
			r.rem = t;
		end
		return r;
	endfunction

	assign init.rem = '0;
	assign init.nq = num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < awb_pkg::DIV_STAGES; i++) valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < awb_pkg::DIV_STAGES; i++) valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(init, den);
			den_s[0] <= den;
			tag_s[0] <= tag;
			for (int i = 1; i < awb_pkg::DIV_STAGES; i++) begin
				st_s[i] <= div_step(st_s[i-1], den_s[i-1]);
				den_s[i] <= den_s[i-1];
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	assign out_valid = valid_s[awb_pkg::DIV_STAGES-1];
	assign quo = st_s[awb_pkg::DIV_STAGES-1].nq;
	assign out_tag = tag_s[awb_pkg::DIV_STAGES-1];

endmodule

/* rtl/awb_gain_register_writer_top.sv */
// awb gain register writer: top level with ratio and gain dividers and write sequencer
`timescale 1ns / 1ps
// throughput: one item per cycle into the pipeline while the sequencer is not busy;
// the sequencer sends one result per cycle with out_ready high, one to six per item
// reset: asynchronous, clears all valid bits and the sequencer; no results pending
module awb_gain_register_writer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [awb_pkg::RATIO_BITS-1:0]   measured_rg,
	input  logic [awb_pkg::RATIO_BITS-1:0]   measured_bg,
	input  logic [awb_pkg::RATIO_BITS-1:0]   golden_rg,
	input  logic [awb_pkg::RATIO_BITS-1:0]   golden_bg,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       kind,
	output logic [15:0]                      reg_addr,
	output logic [7:0]                       reg_data,
	output logic                             last
);

	localparam int DW = awb_pkg::DEN_W;
	localparam int NW = awb_pkg::NUM_W;

	logic en;

	// stage 1: products
	logic            valid_s1;
	logic            err_s1;
	logic [DW-1:0]   prod_r_s1, prod_b_s1, mrg_s1, mbg_s1;

	// ratio dividers
	logic              dr_valid, db_valid;
	logic [NW-1:0]     dr_quo, db_quo;
	awb_pkg::div_tag_t dr_tag, db_tag, t1;

	// stage 2: base
	logic            valid_s2;
	logic            err_s2;
	logic [DW-1:0]   rr_s2, br_s2, base_s2;
	logic [DW-1:0]   rr, br, base_c;

	// gain dividers
	logic              gr_valid, gg_valid, gb_valid;
	logic [NW-1:0]     gr_quo, gg_quo, gb_quo;
	awb_pkg::div_tag_t gr_tag, gg_tag, gb_tag, t2;
	logic [15:0]       sat_r, sat_g, sat_b;

	// sequencer
	logic                        em_valid_q;
	logic                        em_err_q;
	logic [awb_pkg::SLOTS-1:0]   em_mask_q;
	logic [15:0]                 em_gr_q, em_gg_q, em_gb_q;
	logic [2:0]                  slot;
	logic                        em_last;
	logic [15:0]                 cur_gain;

	assign en = !em_valid_q || (out_ready && em_last);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= dr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= (measured_rg == '0) || (measured_bg == '0) ||
				(golden_rg == '0) || (golden_bg == '0);
			prod_r_s1 <= DW'(golden_rg * awb_pkg::UNITY_RATIO);
			prod_b_s1 <= DW'(golden_bg * awb_pkg::UNITY_RATIO);
			mrg_s1 <= DW'(measured_rg);
			mbg_s1 <= DW'(measured_bg);
		end
	end

	assign t1.err = err_s1;

	awb_div u_div_r (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s1),
		.num(NW'(prod_r_s1)), .den(mrg_s1), .tag(t1),
		.out_valid(dr_valid), .quo(dr_quo), .out_tag(dr_tag)
	);

	awb_div u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s1),
		.num(NW'(prod_b_s1)), .den(mbg_s1), .tag(t1),
		.out_valid(db_valid), .quo(db_quo), .out_tag(db_tag)
	);

	assign rr = dr_quo[DW-1:0];
	assign br = db_quo[DW-1:0];

	always_comb begin
		if (rr < DW'(awb_pkg::UNITY_RATIO) || br < DW'(awb_pkg::UNITY_RATIO)) begin
			base_c = (rr < br) ? rr : br;
		end else begin
			base_c = DW'(awb_pkg::UNITY_RATIO);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s2 <= rr;
			br_s2 <= br;
			base_s2 <= base_c;
			err_s2 <= dr_tag.err || db_tag.err || (base_c == '0);
		end
	end

	assign t2.err = err_s2;

	awb_div u_gain_r (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s2),
		.num(NW'({rr_s2, 10'b0})), .den(base_s2), .tag(t2),
		.out_valid(gr_valid), .quo(gr_quo), .out_tag(gr_tag)
	);

	awb_div u_gain_g (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s2),
		.num(NW'({awb_pkg::UNITY_RATIO, 10'b0})), .den(base_s2), .tag(t2),
		.out_valid(gg_valid), .quo(gg_quo), .out_tag(gg_tag)
	);

	awb_div u_gain_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s2),
		.num(NW'({br_s2, 10'b0})), .den(base_s2), .tag(t2),
		.out_valid(gb_valid), .quo(gb_quo), .out_tag(gb_tag)
	);

	assign sat_r = (gr_quo > NW'(awb_pkg::GAIN_MAX)) ? awb_pkg::GAIN_MAX : gr_quo[15:0];
	assign sat_g = (gg_quo > NW'(awb_pkg::GAIN_MAX)) ? awb_pkg::GAIN_MAX : gg_quo[15:0];
	assign sat_b = (gb_quo > NW'(awb_pkg::GAIN_MAX)) ? awb_pkg::GAIN_MAX : gb_quo[15:0];

	// lowest pending slot
	always_comb begin
		slot = 3'd0;
		for (int i = awb_pkg::SLOTS - 1; i >= 0; i--) begin
			if (em_mask_q[i]) slot = 3'(i);
		end
	end

	assign em_last = (em_mask_q & (em_mask_q - 1'b1)) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_mask_q <= '0;
		end else if (en) begin
			em_valid_q <= gr_valid;
			if (!gr_valid) begin
				em_mask_q <= '0;
			end else if (gr_tag.err || gg_tag.err || gb_tag.err) begin
				em_mask_q <= '0;
			end else begin
				em_mask_q <= {{2{sat_b > awb_pkg::UNITY_GAIN}},
					{4{sat_g > awb_pkg::UNITY_GAIN}},
					{2{sat_r > awb_pkg::UNITY_GAIN}}};
			end
		end else if (out_ready) begin
			em_mask_q[slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			em_err_q <= gr_tag.err;
			em_gr_q <= sat_r;
			em_gg_q <= sat_g;
			em_gb_q <= sat_b;
		end
	end

	always_comb begin
		unique case (slot[2:1])
			2'd0: cur_gain = em_gr_q;
			2'd3: cur_gain = em_gb_q;
			default: cur_gain = em_gg_q;
		endcase
	end

	assign out_valid = em_valid_q;
	assign last = em_last;

	always_comb begin
		if (em_mask_q == '0) begin
			kind = em_err_q ? awb_pkg::KIND_ERR : awb_pkg::KIND_NONE;
			reg_addr = '0;
			reg_data = '0;
		end else begin
			kind = awb_pkg::KIND_WRITE;
			reg_addr = awb_pkg::slot_addr(slot);
			reg_data = slot[0] ? cur_gain[7:0] : cur_gain[15:8];
		end
	end

	a_nonwrite_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != awb_pkg::KIND_WRITE |-> last)
		else $error("non-write result not last");

	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == awb_pkg::KIND_WRITE |-> reg_addr[15:8] == 8'h51)
		else $error("write address out of range");

	a_at_most_six: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(em_mask_q) <= 6)
		else $error("more than six writes pending");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("item run broken");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dr_valid == db_valid && gr_valid == gg_valid && gr_valid == gb_valid)
		else $error("divider valid bits out of step");

endmodule
